// ----- hdl/iac_pkg.sv -----
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types, constants and helper functions of the input action
// conditioner.
// ----------------------------------------------------------------------------
package iac_pkg;

  localparam int unsigned NumObjectsDef  = 4;
  localparam int unsigned NumBindingsDef = 4;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned ProdW     = 32;

  // Full scale of a Q1.15 level.
  localparam logic [LevelW-1:0] FullScale = 16'h8000;

  // Physical id layout: the input type sits above the object number.
  localparam int unsigned IdTypeLsb  = 8;
  localparam logic [3:0]  IdTypeBtn  = 4'h0;
  // Ramp steps are products scaled down by this many bits.
  localparam int unsigned StepShift  = 8;
  localparam int unsigned StepW      = ProdW - StepShift;

  localparam logic FuncEvent = 1'b0;
  localparam logic FuncTick  = 1'b1;

  typedef enum logic [1:0] {
    KIND_TRIGGER = 2'd0,
    KIND_TOGGLE  = 2'd1,
    KIND_AXIS    = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_OBJECT_KINDS   = 3'd0,
    REG_PRESS_THRESH   = 3'd1,
    REG_RELEASE_THRESH = 3'd2,
    REG_RAMP_UP        = 3'd3,
    REG_RAMP_DOWN      = 3'd4,
    REG_BINDING_IDS    = 3'd5,
    REG_BINDING_TGTS   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic          func;
    logic [15:0]   phys_id;
    logic [15:0]   in_value;
    logic [15:0]   elapsed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    object_index;
    logic [15:0]   out_value;
    logic          last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0]    object_kinds;
    logic [63:0]   press_thresholds;
    logic [63:0]   release_thresholds;
    logic [63:0]   ramp_up_rates;
    logic [63:0]   ramp_down_rates;
    logic [63:0]   binding_ids;
    logic [11:0]   binding_targets;
  } cfg_t;

  // One 16-bit lane of a register holding four packed values.
  function automatic logic [15:0] field16(input logic [63:0] r, input logic [1:0] k);
    return r[{k, 4'b0000} +: 16];
  endfunction

  function automatic kind_e kind_of(input logic [7:0] kinds, input logic [1:0] k);
    return kind_e'(kinds[{k, 1'b0} +: 2]);
  endfunction

endpackage

// ----- hdl/iac_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// iac_cfg_regs
// Configuration register file, written one register per word.
// ----------------------------------------------------------------------------
module iac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [iac_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [iac_pkg::CfgDataW-1:0]  cfg_data_i,
  output iac_pkg::cfg_t                 cfg_o
);
  import iac_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_OBJECT_KINDS:   cfg_q.object_kinds       <= cfg_data_i[7:0];
        REG_PRESS_THRESH:   cfg_q.press_thresholds   <= cfg_data_i;
        REG_RELEASE_THRESH: cfg_q.release_thresholds <= cfg_data_i;
        REG_RAMP_UP:        cfg_q.ramp_up_rates      <= cfg_data_i;
        REG_RAMP_DOWN:      cfg_q.ramp_down_rates    <= cfg_data_i;
        REG_BINDING_IDS:    cfg_q.binding_ids        <= cfg_data_i;
        REG_BINDING_TGTS:   cfg_q.binding_targets    <= cfg_data_i[11:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

// ----- hdl/iac_ramp_unit.sv -----
// ----------------------------------------------------------------------------
// iac_ramp_unit
// Shared ramp datapath: registered multiply of elapsed time by a rate, then
// a saturating add toward full scale or subtract toward zero.
// ----------------------------------------------------------------------------
module iac_ramp_unit (
  input  logic                       clk_i,
  input  logic                       mul_en_i,
  input  logic                       up_i,
  input  logic [iac_pkg::LevelW-1:0] pos_i,
  input  logic [15:0]                elapsed_i,
  input  logic [15:0]                rate_i,
  output logic [iac_pkg::LevelW-1:0] new_pos_o
);
  import iac_pkg::*;

  logic [ProdW-1:0]  prod_q;
  logic              up_q;
  logic [LevelW-1:0] pos_q;
  logic [StepW-1:0]  step;
  logic [LevelW-1:0] room;

  // Operands are captured together with the product.
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= ProdW'(elapsed_i) * ProdW'(rate_i);
      up_q   <= up_i;
      pos_q  <= pos_i;
    end
  end

  always_comb begin
    step = prod_q[ProdW-1:StepShift];
    room = FullScale - pos_q;
    if (up_q) begin
      if (step >= StepW'(room)) new_pos_o = FullScale;
      else                      new_pos_o = pos_q + step[LevelW-1:0];
    end else begin
      if (step >= StepW'(pos_q)) new_pos_o = '0;
      else                       new_pos_o = pos_q - step[LevelW-1:0];
    end
  end

endmodule

// ----- hdl/input_action_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// input_action_conditioner_top
// Maps physical input words onto logical objects and ramps axis positions.
// ----------------------------------------------------------------------------
// Usage: input words arrive on the in_* valid/ready channel. An event word
// (func 0) is looked up in the binding table and yields at most one result
// word; a tick word (func 1) ramps every axis object not yet at its target
// end and yields one result word per such axis. Result words leave on the
// out_* channel, the final one of each input word carries last_result. An
// event word's result is loaded into the output register in the same cycle
// as the event state returns to idle, so the block is ready again as it is
// presented. A tick keeps in_ready low while it scans each object in turn,
// with an update step per such axis and a closing scan step, as a single
// ramp multiplier is reused object by object. One word is taken at a time.
// The output register lets the sequencer finish its current result while
// the receiver stalls; when it is full the sequencer waits and no state
// changes until the result can be placed.
// Configuration words are written on the cfg_* channel, always ready, and
// must only be sent while the block is idle.
// Reset clears all configuration, down flags and positions to zero.
// ----------------------------------------------------------------------------
module input_action_conditioner_top #(
  parameter int unsigned NUM_OBJECTS  = iac_pkg::NumObjectsDef,
  parameter int unsigned NUM_BINDINGS = iac_pkg::NumBindingsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  iac_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output iac_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [iac_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [iac_pkg::CfgDataW-1:0]  cfg_data_i
);
  import iac_pkg::*;

  localparam int unsigned ObjIdxW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int unsigned ObjCntW = $clog2(NUM_OBJECTS + 1);
  localparam logic [ObjCntW-1:0] ObjLast = ObjCntW'(NUM_OBJECTS);
  localparam logic [2:0]         NumObj  = 3'(NUM_OBJECTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  cfg_t cfg;

  state_e              state_q;
  in_item_t            item_q;
  logic [ObjCntW-1:0]  scan_q;
  logic [NUM_OBJECTS-1:0] mask_q;
  logic                down_q [NUM_OBJECTS];
  logic [LevelW-1:0]   pos_q  [NUM_OBJECTS];
  logic                out_valid_q;
  out_item_t           out_q;

  iac_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Event path: binding lookup and down-flag update.
  logic              evt_found;
  logic [1:0]        evt_obj;
  logic              evt_ok;
  logic [ObjIdxW-1:0] evt_idx;
  logic [LevelW-1:0] evt_level;
  logic              evt_button;
  kind_e             evt_kind;
  logic              evt_was;
  logic              evt_down;
  logic              evt_emit;
  logic              evt_set_pos;
  logic [LevelW-1:0] evt_val;

  always_comb begin
    evt_found = 1'b0;
    evt_obj   = '0;
    // Walk downward so the lowest-numbered matching binding wins.
    for (int b = NUM_BINDINGS - 1; b >= 0; b--) begin
      if (cfg.binding_targets[3*b+2] &&
          field16(cfg.binding_ids, 2'(b)) == item_q.phys_id) begin
        evt_found = 1'b1;
        evt_obj   = cfg.binding_targets[3*b +: 2];
      end
    end
    evt_ok     = evt_found && ({1'b0, evt_obj} < NumObj);
    evt_idx    = evt_obj[ObjIdxW-1:0];
    evt_level  = (item_q.in_value > FullScale) ? FullScale : item_q.in_value;
    evt_button = (item_q.phys_id[IdTypeLsb +: 4] == IdTypeBtn);
    evt_kind   = kind_of(cfg.object_kinds, evt_obj);
    evt_was    = down_q[evt_idx];
    evt_down    = evt_was;
    evt_emit    = 1'b0;
    evt_set_pos = 1'b0;
    evt_val     = '0;
    unique case (evt_kind)
      KIND_AXIS: begin
        if (evt_button) begin
          evt_down = (evt_level == FullScale);
        end else begin
          evt_set_pos = 1'b1;
          evt_emit    = 1'b1;
          evt_val     = evt_level;
        end
      end
      KIND_TRIGGER, KIND_TOGGLE: begin
        if (evt_button) begin
          evt_down = (evt_level == FullScale);
        end else begin
          if (evt_level > field16(cfg.press_thresholds, evt_obj))   evt_down = 1'b1;
          if (evt_level < field16(cfg.release_thresholds, evt_obj)) evt_down = 1'b0;
        end
        if (evt_kind == KIND_TRIGGER) evt_emit = evt_down && !evt_was;
        else                          evt_emit = evt_down != evt_was;
        evt_val = evt_down ? FullScale : '0;
      end
      default: begin
        // Unused kind: the event is ignored.
      end
    endcase
    evt_emit    = evt_emit && evt_ok;
    evt_set_pos = evt_set_pos && evt_ok;
  end

  // A result word is placed into the output register in this cycle.
  logic out_load;
  assign out_load = out_free &&
                    (((state_q == ST_EVENT) && evt_emit) || (state_q == ST_UPDATE));

  // Tick path: axis objects not yet at the end they ramp toward, known before
  // the scan starts since each object's step depends on its own state only.
  logic [NUM_OBJECTS-1:0] tick_mask;
  always_comb begin
    for (int k = 0; k < NUM_OBJECTS; k++) begin
      tick_mask[k] = (kind_of(cfg.object_kinds, 2'(k)) == KIND_AXIS) &&
                     (down_q[k] ? (pos_q[k] < FullScale) : (pos_q[k] != '0));
    end
  end

  logic [ObjIdxW-1:0]     scan_idx;
  logic [1:0]             scan_obj;
  logic                   scan_up;
  logic [15:0]            scan_rate;
  logic [LevelW-1:0]      ramp_pos;
  logic                   mul_en;
  logic [NUM_OBJECTS-1:0] mask_left;

  always_comb begin
    scan_idx  = scan_q[ObjIdxW-1:0];
    scan_obj  = 2'(scan_q);
    scan_up   = down_q[scan_idx];
    scan_rate = scan_up ? field16(cfg.ramp_up_rates, scan_obj)
                        : field16(cfg.ramp_down_rates, scan_obj);
    mul_en    = (state_q == ST_SCAN) && (scan_q != ObjLast) && mask_q[scan_idx];
    mask_left = mask_q;
    mask_left[scan_idx] = 1'b0;
  end

  iac_ramp_unit u_ramp_unit (
    .clk_i     (clk_i),
    .mul_en_i  (mul_en),
    .up_i      (scan_up),
    .pos_i     (pos_q[scan_idx]),
    .elapsed_i (item_q.elapsed),
    .rate_i    (scan_rate),
    .new_pos_o (ramp_pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      scan_q      <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int k = 0; k < NUM_OBJECTS; k++) begin
        down_q[k] <= 1'b0;
        pos_q[k]  <= '0;
      end
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            scan_q <= '0;
            mask_q <= tick_mask;
            state_q <= (in_data_i.func == FuncTick) ? ST_SCAN : ST_EVENT;
          end
        end
        ST_EVENT: begin
          if (!evt_emit || out_free) begin
            if (evt_ok) down_q[evt_idx] <= evt_down;
            if (evt_set_pos) pos_q[evt_idx] <= evt_val;
            if (evt_emit) begin
              out_q.object_index <= evt_obj;
              out_q.out_value    <= evt_val;
              out_q.last_result  <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_q == ObjLast) begin
            state_q <= ST_IDLE;
          end else if (mask_q[scan_idx]) begin
            state_q <= ST_UPDATE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            pos_q[scan_idx]    <= ramp_pos;
            out_q.object_index <= scan_obj;
            out_q.out_value    <= ramp_pos;
            out_q.last_result  <= (mask_left == '0);
            mask_q             <= mask_left;
            scan_q             <= scan_q + 1'b1;
            state_q            <= ST_SCAN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/input_action_conditioner_top_tb.sv -----
// ----------------------------------------------------------------------------
// input_action_conditioner_top_tb
// Self-checking testbench of the input action conditioner. A short table of
// directed words (reset behavior, field extremes, unbound and ignored ids,
// duplicate bindings, kinds changed at run time) is followed by random
// phases under several register settings. Every accepted input word runs
// through a predictor of the binding lookup, the hysteresis and the axis
// ramps, and each result word is compared field by field with the oldest
// expected one. Both channels idle at random, including one long receiver
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module input_action_conditioner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iac_pkg::*;

  // Cycles to let pass after the last expected word before touching
  // the registers.
  localparam int DrainCycles = 16;

  // How a directed row is checked: by the predictor, or against a typed
  // answer of no result or of exactly one result.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } chk_e;

  typedef enum logic [1:0] {
    SET_RANDOM,
    SET_MAX,
    SET_ZERO,
    SET_ONES
  } setting_e;

  typedef struct {
    logic        is_reg;
    reg_idx_e    idx;
    logic [63:0] data;
    in_item_t    word;
    chk_e        chk;
    logic [1:0]  obj;
    logic [15:0] val;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  // Predictor copy of the registers and of the object state.
  logic [7:0]  kinds_r;
  logic [63:0] press_r;
  logic [63:0] release_r;
  logic [63:0] up_r;
  logic [63:0] dn_r;
  logic [63:0] ids_r;
  logic [11:0] tgts_r;
  logic        down_r [4];
  logic [15:0] pos_r [4];

  // Result words expected from the block, oldest first, and the words that
  // the word being predicted produces.
  out_item_t action_q[$];
  out_item_t step_q[$];
  out_item_t want;

  row_t dir_rows[$];

  int  err_cnt     = 0;
  bit  tx_gaps_on  = 1'b1;
  bit  rx_stall_on = 1'b1;
  int  hold_left   = 0;

  input_action_conditioner_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One 16-bit lane of a register that packs four values.
  function automatic logic [15:0] lane16(input logic [63:0] r, input int k);
    return r[16*k +: 16];
  endfunction

  function automatic void add_action(input logic [1:0] obj, input logic [15:0] v);
    out_item_t a;
    a.object_index = obj;
    a.out_value    = v;
    a.last_result  = 1'b0;
    step_q.push_back(a);
  endfunction

  // Works out the result words of one input word and advances the predicted
  // down flags and axis positions.
  function automatic void predict_actions(input in_item_t w);
    logic [15:0] lvl;
    logic [31:0] step;
    logic [31:0] room;
    logic [15:0] p;
    logic [2:0]  t;
    logic [1:0]  obj;
    logic        found;
    logic        is_btn;
    logic        was;
    logic        d;
    kind_e       kd;
    out_item_t   tail;
    step_q.delete();
    // Levels above full scale count as full scale.
    lvl = (w.in_value > FullScale) ? FullScale : w.in_value;
    if (w.func == FuncTick) begin
      for (int k = 0; k < 4; k++) begin
        p = pos_r[k];
        if (kind_e'(kinds_r[2*k +: 2]) != KIND_AXIS) continue;
        if (down_r[k] && p < FullScale) begin
          step = (32'(w.elapsed) * 32'(lane16(up_r, k))) >> StepShift;
          room = 32'(FullScale) - 32'(p);
          p = (step >= room) ? FullScale : p + step[15:0];
        end else if (!down_r[k] && p != 16'd0) begin
          step = (32'(w.elapsed) * 32'(lane16(dn_r, k))) >> StepShift;
          p = (step >= 32'(p)) ? 16'd0 : p - step[15:0];
        end else begin
          continue;
        end
        pos_r[k] = p;
        add_action(2'(k), p);
      end
    end else begin
      // The lowest-numbered valid binding with a matching id wins.
      found = 1'b0;
      obj   = 2'd0;
      for (int b = 0; b < 4; b++) begin
        t = tgts_r[3*b +: 3];
        if (!found && t[2] && lane16(ids_r, b) == w.phys_id) begin
          obj   = t[1:0];
          found = 1'b1;
        end
      end
      if (found) begin
        kd     = kind_e'(kinds_r[2*obj +: 2]);
        is_btn = (w.phys_id[IdTypeLsb +: 4] == IdTypeBtn);
        was    = down_r[obj];
        if (kd == KIND_AXIS) begin
          if (is_btn) begin
            down_r[obj] = (lvl == FullScale);
          end else begin
            pos_r[obj] = lvl;
            add_action(obj, lvl);
          end
        end else if (kd != KIND_UNUSED) begin
          d = was;
          if (is_btn) begin
            d = (lvl == FullScale);
          end else begin
            if (lvl > lane16(press_r, obj)) d = 1'b1;
            if (lvl < lane16(release_r, obj)) d = 1'b0;
          end
          down_r[obj] = d;
          if ((kd == KIND_TRIGGER && d && !was) || (kd == KIND_TOGGLE && d != was)) begin
            add_action(obj, d ? FullScale : 16'd0);
          end
        end
      end
    end
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.last_result = 1'b1;
      step_q.push_back(tail);
    end
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [63:0] d);
    case (idx)
      REG_OBJECT_KINDS:   kinds_r   = d[7:0];
      REG_PRESS_THRESH:   press_r   = d;
      REG_RELEASE_THRESH: release_r = d;
      REG_RAMP_UP:        up_r      = d;
      REG_RAMP_DOWN:      dn_r      = d;
      REG_BINDING_IDS:    ids_r     = d;
      REG_BINDING_TGTS:   tgts_r    = d[11:0];
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random input word: mostly events on bound ids and ticks with short
  // elapsed times, the rest noise on arbitrary ids.
  function automatic in_item_t rand_word();
    in_item_t w;
    int       r;
    r = $urandom_range(0, 99);
    w.func     = FuncEvent;
    w.phys_id  = 16'($urandom);
    w.in_value = 16'($urandom);
    w.elapsed  = 16'($urandom);
    if (r < 30) begin
      w.func = FuncTick;
      r = $urandom_range(0, 9);
      if (r < 7) begin
        w.elapsed = 16'($urandom_range(0, 8));
      end else if (r < 9) begin
        w.elapsed = 16'($urandom_range(0, 255));
      end
    end else if (r < 90) begin
      w.phys_id = lane16(ids_r, $urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: w.in_value = 16'd0;
        1: w.in_value = FullScale;
        2: w.in_value = 16'($urandom_range(0, 32768));
        default: ;
      endcase
    end
    return w;
  endfunction

  function automatic void add_reg(input reg_idx_e idx, input logic [63:0] d);
    row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    r.word   = '0;
    r.chk    = CHK_MODEL;
    r.obj    = 2'd0;
    r.val    = 16'd0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_word(input logic f, input logic [15:0] id,
                                   input logic [15:0] v, input logic [15:0] el,
                                   input chk_e c, input logic [1:0] o,
                                   input logic [15:0] ov);
    row_t r;
    r.is_reg        = 1'b0;
    r.idx           = REG_OBJECT_KINDS;
    r.data          = '0;
    r.word.func     = f;
    r.word.phys_id  = id;
    r.word.in_value = v;
    r.word.elapsed  = el;
    r.chk           = c;
    r.obj           = o;
    r.val           = ov;
    dir_rows.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_v);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t: %s: got %h, expected %h", $time, what, got, exp_v);
    end
  endtask

  // Offers one input word after an optional gap and waits until it is
  // accepted, then records what it should produce.
  task automatic send_word(input in_item_t w, input chk_e chk, input logic [1:0] obj,
                           input logic [15:0] val);
    int        gap;
    out_item_t typed;
    gap = tx_gaps_on ? rand_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    // The predictor runs for typed rows too so that its state stays in step.
    predict_actions(w);
    case (chk)
      CHK_MODEL: begin
        foreach (step_q[i]) action_q.push_back(step_q[i]);
      end
      CHK_ONE: begin
        typed.object_index = obj;
        typed.out_value    = val;
        typed.last_result  = 1'b1;
        action_q.push_back(typed);
      end
      default: ;
    endcase
  endtask

  // Stops offering words, waits for every expected word, then lets a word
  // that produces nothing finish inside the block.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (action_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] d);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Writes all seven registers with a fresh setting.
  task automatic new_setting(input setting_e s);
    logic [7:0]  kd;
    logic [63:0] pr;
    logic [63:0] rl;
    logic [63:0] up;
    logic [63:0] dn;
    logic [63:0] ids;
    logic [11:0] tg;
    kd = 8'($urandom);
    up = {$urandom, $urandom};
    dn = {$urandom, $urandom};
    for (int b = 0; b < 4; b++) begin
      pr[16*b +: 16]  = 16'($urandom_range(0, 32768));
      rl[16*b +: 16]  = 16'($urandom_range(0, 32768));
      // Each binding is a button or, with even odds, an axis of some nonzero type.
      ids[16*b +: 16] = {4'($urandom),
                         ($urandom_range(0, 1) != 0) ? IdTypeBtn : 4'($urandom_range(1, 15)),
                         8'($urandom)};
    end
    // Now and then the last binding repeats the id of the first one.
    if ($urandom_range(0, 3) == 0) ids[63:48] = ids[15:0];
    tg = 12'($urandom);
    if ($urandom_range(0, 3) != 0) tg |= 12'h924;
    case (s)
      SET_MAX: begin
        pr = '1;
        up = '1;
        dn = '1;
      end
      SET_ZERO: begin
        pr = '0;
        rl = '0;
        up = '0;
        dn = '0;
      end
      SET_ONES: begin
        kd  = '1;
        pr  = '1;
        rl  = '1;
        up  = '1;
        dn  = '1;
        ids = '1;
        tg  = '1;
      end
      default: ;
    endcase
    write_reg(REG_OBJECT_KINDS, 64'(kd));
    write_reg(REG_PRESS_THRESH, pr);
    write_reg(REG_RELEASE_THRESH, rl);
    write_reg(REG_RAMP_UP, up);
    write_reg(REG_RAMP_DOWN, dn);
    write_reg(REG_BINDING_IDS, ids);
    write_reg(REG_BINDING_TGTS, 64'(tg));
  endtask

  // Receiver: ready changes only at the falling edge. A long hold requested
  // by the main sequence is counted down here, cycle by cycle.
  initial begin : rx_side
    int gap_left;
    gap_left  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 3) == 0) gap_left = rand_gap();
      end
    end
  end

  // Result checker: each accepted result word against the oldest expected.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (action_q.size() == 0) begin
        report_mismatch("result word with none expected, out_value", out_data.out_value,
                        16'h0000);
      end else begin
        want = action_q.pop_front();
        if (out_data.object_index !== want.object_index) begin
          report_mismatch("object_index", 16'(out_data.object_index),
                          16'(want.object_index));
        end
        if (out_data.out_value !== want.out_value) begin
          report_mismatch("out_value", out_data.out_value, want.out_value);
        end
        if (out_data.last_result !== want.last_result) begin
          report_mismatch("last_result", 16'(out_data.last_result),
                          16'(want.last_result));
        end
      end
    end
  end

  // Hard limit on the run, far beyond the slowest passing run.
  initial begin
    #2_000_000;
    $display("input_action_conditioner_top regression: fail");
    $finish;
  end

  initial begin
    int n_items;
    setting_e set_sel;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OBJECT_KINDS;
    cfg_data  = '0;
    rst_ni    = 1'b0;
    kinds_r   = '0;
    press_r   = '0;
    release_r = '0;
    up_r      = '0;
    dn_r      = '0;
    ids_r     = '0;
    tgts_r    = '0;
    for (int k = 0; k < 4; k++) begin
      down_r[k] = 1'b0;
      pos_r[k]  = 16'd0;
    end

    // Out of reset nothing is bound and every object is a trigger, so
    // neither an event nor a tick may produce anything.
    add_word(FuncEvent, 16'h0000, FullScale, 16'hFFFF, CHK_NONE, 2'd0, 16'd0);
    add_word(FuncTick, 16'hFFFF, 16'hFFFF, 16'hFFFF, CHK_NONE, 2'd0, 16'd0);

    // Object 0 trigger, 1 toggle, 2 and 3 axes. Bindings: a button on the
    // trigger, an axis on the toggle, a button on axis 2, an axis on axis 3.
    add_reg(REG_OBJECT_KINDS, 64'hA4);
    add_reg(REG_PRESS_THRESH, 64'h0000_0000_6000_4000);
    add_reg(REG_RELEASE_THRESH, 64'h0000_0000_1000_2000);
    add_reg(REG_RAMP_UP, 64'h0100_FFFF_0000_0000);
    add_reg(REG_RAMP_DOWN, 64'h0001_FFFF_0000_0000);
    add_reg(REG_BINDING_IDS, 64'hF1FF_0002_0101_0000);
    add_reg(REG_BINDING_TGTS, 64'hFAC);
    // Trigger: press edge reports, holding and releasing do not.
    add_word(FuncEvent, 16'h0000, FullScale, 16'h0000, CHK_ONE, 2'd0, FullScale);
    add_word(FuncEvent, 16'h0000, FullScale, 16'hFFFF, CHK_NONE, 2'd0, 16'd0);
    add_word(FuncEvent, 16'h0000, 16'h7FFF, 16'h0000, CHK_NONE, 2'd0, 16'd0);
    // Toggle through hysteresis; a level above full scale is clamped.
    add_word(FuncEvent, 16'h0101, 16'hFFFF, 16'h0000, CHK_ONE, 2'd1, FullScale);
    add_word(FuncEvent, 16'h0101, 16'h3000, 16'h0000, CHK_MODEL, 2'd0, 16'd0);
    add_word(FuncEvent, 16'h0101, 16'h0000, 16'h0000, CHK_ONE, 2'd1, 16'h0000);
    // An id that no binding holds.
    add_word(FuncEvent, 16'h1234, FullScale, 16'h0000, CHK_NONE, 2'd0, 16'd0);
    // Axis level passed through, clamped to full scale.
    add_word(FuncEvent, 16'hF1FF, 16'hFFFF, 16'h0000, CHK_ONE, 2'd3, FullScale);
    // A button on an axis only sets its down flag.
    add_word(FuncEvent, 16'h0002, FullScale, 16'h0000, CHK_NONE, 2'd0, 16'd0);
    // Ramps: a small step, saturation at both ends, a zero step.
    add_word(FuncTick, 16'h0000, 16'h0000, 16'h0001, CHK_MODEL, 2'd0, 16'd0);
    add_word(FuncTick, 16'h0000, 16'h0000, 16'hFFFF, CHK_MODEL, 2'd0, 16'd0);
    add_word(FuncTick, 16'h0000, 16'h0000, 16'h0000, CHK_MODEL, 2'd0, 16'd0);
    add_word(FuncEvent, 16'h0002, 16'h0000, 16'h0000, CHK_NONE, 2'd0, 16'd0);
    add_word(FuncTick, 16'h0000, 16'h0000, 16'hFFFF, CHK_MODEL, 2'd0, 16'd0);
    add_word(FuncEvent, 16'hF1FF, 16'h0000, 16'h0000, CHK_ONE, 2'd3, 16'h0000);
    add_word(FuncTick, 16'h0000, 16'h0000, 16'h0005, CHK_MODEL, 2'd0, 16'd0);

    // Object 0 unused, 1 trigger, 2 toggle (was an axis), 3 axis. Both id
    // pairs are duplicated: the invalid binding 0 is skipped, binding 2
    // shadows binding 3. Thresholds at zero.
    add_reg(REG_OBJECT_KINDS, 64'h93);
    add_reg(REG_PRESS_THRESH, 64'h0);
    add_reg(REG_RELEASE_THRESH, 64'h0);
    add_reg(REG_BINDING_IDS, 64'h0105_0105_0005_0005);
    add_reg(REG_BINDING_TGTS, 64'hBA0);
    add_word(FuncEvent, 16'h0005, FullScale, 16'h0000, CHK_NONE, 2'd0, 16'd0);
    add_word(FuncEvent, 16'h0105, 16'h0001, 16'h0000, CHK_ONE, 2'd2, FullScale);
    add_word(FuncEvent, 16'h0105, 16'h0000, 16'h0000, CHK_NONE, 2'd0, 16'd0);
    add_word(FuncEvent, 16'h0105, FullScale, 16'h0000, CHK_MODEL, 2'd0, 16'd0);
    add_word(FuncTick, 16'h0000, 16'h0000, 16'h00FF, CHK_MODEL, 2'd0, 16'd0);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].chk, dir_rows[i].obj, dir_rows[i].val);
      end
    end

    // Random phases, each under a new setting. Phase 2 runs without any
    // idling; in phase 3 the receiver holds off for a long stretch while
    // the sender keeps offering words back to back.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        1:       set_sel = SET_MAX;
        2:       set_sel = SET_ZERO;
        5:       set_sel = SET_ONES;
        default: set_sel = SET_RANDOM;
      endcase
      new_setting(set_sel);
      tx_gaps_on  = (p != 2 && p != 3);
      rx_stall_on = (p != 2);
      if (p == 3) hold_left = 300;
      n_items = (p == 5) ? 10 : 28;
      for (int n = 0; n < n_items; n++) begin
        // Once mid-phase the sender pauses until every result is in.
        if (p == 0 && n == 14) wait_idle();
        send_word(rand_word(), CHK_MODEL, 2'd0, 16'd0);
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("input_action_conditioner_top regression: pass");
    end else begin
      $display("input_action_conditioner_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/iac_pkg.sv
hdl/iac_cfg_regs.sv
hdl/iac_ramp_unit.sv
hdl/input_action_conditioner_top.sv
verif/input_action_conditioner_top_tb.sv
